/* hw/rtl/klim_pkg.sv */
package klim_pkg;

  localparam int ENTRIES_DEF = 16;

  localparam logic [31:0] ONE_TOKEN       = 32'h0001_0000;
  localparam logic [31:0] NO_REFILL_RETRY = 32'd3600;
  localparam int          NEED_W          = 17;

  localparam logic [15:0] CAPACITY_RST = 16'd10;
  localparam logic [31:0] REFILL_RST   = 32'd66;
  localparam logic [29:0] TPS_RST      = 30'd1000;
  localparam logic [31:0] PRUNE_RST    = 32'd300000;

  typedef enum logic [1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_REFILL   = 2'd1,
    CFG_TPS      = 2'd2,
    CFG_PRUNE    = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MUL,
    S_PSEC,
    S_SUM,
    S_POST,
    S_DIV,
    S_SWCHK,
    S_SW_RD,
    S_SW_MUL,
    S_SW_CHK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] tokens;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    logic take_in;
    logic rd;
    logic chk;
    logic mul;
    logic psec;
    logic sum;
    logic div_start;
    logic sw_start;
    logic sw_mul;
    logic sw_chk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_div;
    logic sweep_due;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

/* hw/rtl/klim_div.sv */
// Restoring divider, ceiling quotient of a 17-bit dividend.
module klim_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [klim_pkg::NEED_W-1:0] dividend,
  input  logic [61:0]                 divisor,
  output logic                        done,
  output logic [31:0]                 quotient
);

  localparam int CW = $clog2(klim_pkg::NEED_W + 1);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [62:0]                 rem;
  logic [klim_pkg::NEED_W-1:0] dv;
  logic [klim_pkg::NEED_W-1:0] q;
  logic [62:0]                 rem_sh;
  logic                        ge;

  assign rem_sh = {rem[61:0], dv[klim_pkg::NEED_W-1]};
  assign ge     = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(klim_pkg::NEED_W);
        rem  <= '0;
        dv   <= dividend;
        q    <= '0;
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          rem <= ge ? rem_sh - {1'b0, divisor} : rem_sh;
          q   <= {q[klim_pkg::NEED_W-2:0], ge};
          dv  <= {dv[klim_pkg::NEED_W-2:0], 1'b0};
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // quotient never exceeds 2^16, so no saturation is reachable
  assign quotient = 32'(q) + 32'(rem != '0);

endmodule

/* hw/rtl/klim_ctrl.sv */
module klim_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  klim_pkg::sts_t   sts,
  output klim_pkg::cmd_t   cmd
);

  klim_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= klim_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      klim_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_in = 1'b1;
          state_next  = klim_pkg::S_RD;
        end
      end
      klim_pkg::S_RD: begin
        cmd.rd     = 1'b1;
        state_next = klim_pkg::S_CHK;
      end
      klim_pkg::S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = sts.idx_last ? klim_pkg::S_MUL : klim_pkg::S_RD;
      end
      klim_pkg::S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = klim_pkg::S_PSEC;
      end
      klim_pkg::S_PSEC: begin
        cmd.psec   = 1'b1;
        state_next = klim_pkg::S_SUM;
      end
      klim_pkg::S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = klim_pkg::S_POST;
      end
      klim_pkg::S_POST: begin
        if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = klim_pkg::S_DIV;
        end else begin
          state_next = klim_pkg::S_SWCHK;
        end
      end
      klim_pkg::S_DIV: begin
        if (sts.div_done) begin
          state_next = klim_pkg::S_SWCHK;
        end
      end
      klim_pkg::S_SWCHK: begin
        if (sts.sweep_due) begin
          cmd.sw_start = 1'b1;
          state_next   = klim_pkg::S_SW_RD;
        end else begin
          state_next = klim_pkg::S_OUT;
        end
      end
      klim_pkg::S_SW_RD: begin
        cmd.rd     = 1'b1;
        state_next = klim_pkg::S_SW_MUL;
      end
      klim_pkg::S_SW_MUL: begin
        cmd.sw_mul = 1'b1;
        state_next = klim_pkg::S_SW_CHK;
      end
      klim_pkg::S_SW_CHK: begin
        cmd.sw_chk = 1'b1;
        state_next = sts.idx_last ? klim_pkg::S_OUT : klim_pkg::S_SW_RD;
      end
      klim_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = klim_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = klim_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/klim_dp.sv */
module klim_dp #(
  parameter int ENTRIES = klim_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [31:0]         client_key,
  input  logic [31:0]         now_ticks,
  input  logic                out_ready,
  output logic                out_valid,
  output logic                allowed,
  output logic [15:0]         remaining,
  output logic [31:0]         retry_after_seconds,
  output logic                table_full,
  input  klim_pkg::cmd_t      cmd,
  output klim_pkg::sts_t      sts
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [15:0] capacity;
  logic [31:0] refill;
  logic [29:0] tps;
  logic [31:0] prune;

  klim_pkg::entry_t mem [ENTRIES];
  klim_pkg::entry_t rd_q;
  logic [ENTRIES-1:0] valid;

  logic [31:0]   key_r, now_r, last_sweep;
  logic [IW-1:0] idx, hit_idx, free_idx, wr_idx;
  logic          hit_f, free_f;
  logic [31:0]   hit_tok, hit_last;
  logic [63:0]   prod;
  logic [61:0]   per_sec;
  logic          need_div;
  logic [klim_pkg::NEED_W-1:0] need;

  logic          res_allowed, res_full;
  logic [15:0]   res_rem;
  logic [31:0]   res_retry;

  logic [31:0] cap, t_cur, tok_new, el_hit, el_sw;
  logic [64:0] sum_hit, sum_sw;
  logic        ok, store;
  logic [29:0] tps_eff;
  logic        div_done;
  logic [31:0] div_q;

  assign cap     = {capacity, 16'h0000};
  assign el_hit  = now_r - hit_last;
  assign el_sw   = now_r - rd_q.last;
  assign sum_hit = 65'(hit_tok) + 65'(prod);
  assign sum_sw  = 65'(rd_q.tokens) + 65'(prod);
  assign t_cur   = !hit_f ? cap : (sum_hit > 65'(cap) ? cap : sum_hit[31:0]);
  assign ok      = t_cur >= klim_pkg::ONE_TOKEN;
  assign tok_new = ok ? t_cur - klim_pkg::ONE_TOKEN : t_cur;
  assign store   = hit_f || free_f;
  assign wr_idx  = hit_f ? hit_idx : free_idx;
  assign tps_eff = (tps == '0) ? 30'd1 : tps;

  assign sts.idx_last  = idx == IW'(ENTRIES - 1);
  assign sts.need_div  = need_div;
  assign sts.sweep_due = (now_r - last_sweep) > prune;
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= klim_pkg::CAPACITY_RST;
      refill   <= klim_pkg::REFILL_RST;
      tps      <= klim_pkg::TPS_RST;
      prune    <= klim_pkg::PRUNE_RST;
    end else if (cfg_we) begin
      case (klim_pkg::cfg_idx_t'(cfg_index))
        klim_pkg::CFG_CAPACITY: capacity <= cfg_data[15:0];
        klim_pkg::CFG_REFILL:   refill   <= cfg_data;
        klim_pkg::CFG_TPS:      tps      <= cfg_data[29:0];
        klim_pkg::CFG_PRUNE:    prune    <= cfg_data;
        default: ;
      endcase
    end
  end

  // bucket store
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_q <= mem[idx];
    end
    if (cmd.sum && store) begin
      mem[wr_idx] <= '{key: key_r, tokens: tok_new, last: now_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      last_sweep <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.sum && !hit_f && free_f) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.sw_chk && valid[idx] && rd_q.key != key_r && sum_sw >= 65'(cap)) begin
        valid[idx] <= 1'b0;
      end
      if (cmd.sw_start) begin
        last_sweep <= now_r;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      key_r  <= client_key;
      now_r  <= now_ticks;
      idx    <= '0;
      hit_f  <= 1'b0;
      free_f <= 1'b0;
    end
    if (cmd.chk) begin
      if (valid[idx] && rd_q.key == key_r && !hit_f) begin
        hit_f    <= 1'b1;
        hit_idx  <= idx;
        hit_tok  <= rd_q.tokens;
        hit_last <= rd_q.last;
      end else if (!valid[idx] && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= idx;
      end
    end
    if ((cmd.chk || cmd.sw_chk) && !sts.idx_last) begin
      idx <= idx + 1'b1;
    end
    if (cmd.sw_start) begin
      idx <= '0;
    end
    if (cmd.mul) begin
      prod <= 64'(el_hit) * 64'(refill);
    end
    if (cmd.sw_mul) begin
      prod <= 64'(el_sw) * 64'(refill);
    end
    if (cmd.psec) begin
      per_sec <= 62'(refill) * 62'(tps_eff);
    end
    if (cmd.sum) begin
      res_allowed <= ok;
      res_full    <= !store;
      res_rem     <= ok ? tok_new[31:16] : 16'h0000;
      res_retry   <= (ok || refill != '0) ? 32'h0 : klim_pkg::NO_REFILL_RETRY;
      need_div    <= !ok && refill != '0;
      need        <= klim_pkg::NEED_W'(klim_pkg::ONE_TOKEN - t_cur);
    end
    if (div_done) begin
      res_retry <= div_q;
    end
    if (cmd.load_out) begin
      allowed             <= res_allowed;
      remaining           <= res_rem;
      retry_after_seconds <= res_retry;
      table_full          <= res_full;
    end
  end

  klim_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (need),
    .divisor  (per_sec),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

/* hw/rtl/keyed_token_bucket_limiter.sv */
// Keyed token-bucket limiter. Each request (client_key, now_ticks) is looked
// up in an ENTRIES-deep bucket table by a sequential scan (a table read, then
// a compare, per entry), refilled by one 32x32 multiply, charged one Q16.16
// token and answered through a registered output. A denied item with a
// nonzero refill also runs the 17-step retry divider; a request that triggers
// a prune sweep also does one table read, one multiply and one compare per
// entry. One item is in work at a time; the next is accepted while the
// previous result waits on out_ready.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
module keyed_token_bucket_limiter #(
  parameter int ENTRIES = klim_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] client_key,
  input  logic [31:0] now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        allowed,
  output logic [15:0] remaining,
  output logic [31:0] retry_after_seconds,
  output logic        table_full
);

  klim_pkg::cmd_t cmd;
  klim_pkg::sts_t sts;

  klim_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  klim_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .client_key          (client_key),
    .now_ticks           (now_ticks),
    .out_ready           (out_ready),
    .out_valid           (out_valid),
    .allowed             (allowed),
    .remaining           (remaining),
    .retry_after_seconds (retry_after_seconds),
    .table_full          (table_full),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

/* tb/keyed_token_bucket_limiter_tb.sv */
module keyed_token_bucket_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    bit        allowed;
    bit [15:0] remaining;
    bit [31:0] retry;
    bit        table_full;
  } verdict_t;

  class limiter_scoreboard;
    bit [15:0] capacity;
    bit [31:0] refill;
    bit [29:0] tps;
    bit [31:0] prune;
    bit        bvalid[NENT];
    bit [31:0] bkey[NENT];
    bit [31:0] btok[NENT];
    bit [31:0] blast[NENT];
    bit [31:0] sweep_time;
    verdict_t  pending[$];
    int        errors;

    function void reset_state();
      capacity = klim_pkg::CAPACITY_RST;
      refill = klim_pkg::REFILL_RST;
      tps = klim_pkg::TPS_RST;
      prune = klim_pkg::PRUNE_RST;
      sweep_time = 0;
      errors = 0;
      for (int i = 0; i < NENT; i++) bvalid[i] = 0;
    endfunction

    function void write_reg(klim_pkg::cfg_idx_t idx, bit [31:0] data);
      case (idx)
        klim_pkg::CFG_CAPACITY: capacity = data[15:0];
        klim_pkg::CFG_REFILL:   refill = data;
        klim_pkg::CFG_TPS:      tps = data[29:0];
        klim_pkg::CFG_PRUNE:    prune = data;
        default: ;
      endcase
    endfunction

    function bit [31:0] level_at(int i, bit [31:0] now);
      bit [31:0] el;
      bit [63:0] t;
      bit [63:0] cap;
      el = now - blast[i];
      cap = 64'(capacity) << 16;
      t = 64'(btok[i]) + 64'(el) * 64'(refill);
      return (t > cap) ? cap[31:0] : t[31:0];
    endfunction

    function void note_request(bit [31:0] key, bit [31:0] now);
      int hit, freei;
      bit [31:0] tok;
      bit stored;
      verdict_t v;
      bit [63:0] per_sec, need, s, cap;
      hit = -1;
      freei = -1;
      stored = 1;
      v = '{0, 0, 0, 0};
      for (int i = 0; i < NENT; i++) begin
        if (bvalid[i]) begin
          if (hit < 0 && bkey[i] == key) hit = i;
        end else if (freei < 0) begin
          freei = i;
        end
      end
      if (hit >= 0) begin
        tok = level_at(hit, now);
      end else begin
        tok = {capacity, 16'h0};
        if (freei >= 0) begin
          hit = freei;
          bvalid[hit] = 1;
          bkey[hit] = key;
        end else begin
          stored = 0;
          v.table_full = 1;
        end
      end
      if (tok >= klim_pkg::ONE_TOKEN) begin
        tok -= klim_pkg::ONE_TOKEN;
        v.allowed = 1;
        v.remaining = tok[31:16];
      end else if (refill == 0) begin
        v.retry = klim_pkg::NO_REFILL_RETRY;
      end else begin
        per_sec = 64'(refill) * 64'((tps == 0) ? 30'd1 : tps);
        need = 64'(klim_pkg::ONE_TOKEN - tok);
        s = need / per_sec + ((need % per_sec) != 0);
        if (s < 1) s = 1;
        v.retry = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
      end
      if (stored) begin
        btok[hit] = tok;
        blast[hit] = now;
      end
      if (32'(now - sweep_time) > prune) begin
        cap = 64'(capacity) << 16;
        for (int i = 0; i < NENT; i++)
          if (bvalid[i] && bkey[i] != key && 64'(level_at(i, now)) >= cap) bvalid[i] = 0;
        sweep_time = now;
      end
      pending.push_back(v);
    endfunction

    function void check_result(bit a, bit [15:0] r, bit [31:0] ra, bit tf);
      verdict_t v;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      v = pending.pop_front();
      if (a !== v.allowed) begin
        $error("allowed: expected %0d got %0d", v.allowed, a); errors++;
      end
      if (r !== v.remaining) begin
        $error("remaining: expected %0d got %0d", v.remaining, r); errors++;
      end
      if (ra !== v.retry) begin
        $error("retry_after_seconds: expected %0d got %0d", v.retry, ra); errors++;
      end
      if (tf !== v.table_full) begin
        $error("table_full: expected %0d got %0d", v.table_full, tf); errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [31:0] client_key, now_ticks;
  logic allowed, table_full;
  logic [15:0] remaining;
  logic [31:0] retry_after_seconds;

  keyed_token_bucket_limiter u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .client_key(client_key),
    .now_ticks(now_ticks), .out_valid(out_valid), .out_ready(out_ready),
    .allowed(allowed), .remaining(remaining),
    .retry_after_seconds(retry_after_seconds), .table_full(table_full)
  );

  limiter_scoreboard sb;
  int send_idle_pct, stall_pct;
  int quiet_cycles;
  bit [31:0] clock_now;
  bit [31:0] key_pool[8];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls, results checked on acceptance
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(allowed, remaining, retry_after_seconds, table_full);
  end

  always @(negedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_cfg(klim_pkg::cfg_idx_t idx, bit [31:0] data);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // valid stays up after a transaction until the next idle gap or drain
  task automatic send_request(bit [31:0] key, bit [31:0] now);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    client_key <= key;
    now_ticks <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(key, now);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // mostly a small key set so buckets get reused and drained
  task automatic random_request();
    bit [31:0] key;
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) key = key_pool[$urandom_range(7)];
    else key = $urandom();
    pick = $urandom_range(99);
    if (pick < 70) clock_now += $urandom_range(50);
    else if (pick < 90) clock_now += $urandom_range(5000);
    else if (pick < 97) clock_now += $urandom_range(400000);
    else clock_now = $urandom();
    send_request(key, clock_now);
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1;
    cfg_we = 0;
    cfg_index = klim_pkg::CFG_CAPACITY;
    cfg_data = 0;
    in_valid = 0;
    client_key = 0;
    now_ticks = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    clock_now = 0;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
    key_pool[0] = 0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: drain a bucket at reset settings, extremes of fields
    for (int i = 0; i < 12; i++) send_request(32'h0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0, 32'h0000_0010);
    send_request(32'h0, 32'd400000);
    // fill the table past capacity with new keys
    for (int i = 0; i < 18; i++) send_request(32'h1000 + i, 32'd400001);
    wait_drained();

    // no refill, one-token buckets
    write_cfg(klim_pkg::CFG_CAPACITY, 32'd1);
    write_cfg(klim_pkg::CFG_REFILL, 32'd0);
    write_cfg(klim_pkg::CFG_TPS, 32'd1);
    write_cfg(klim_pkg::CFG_PRUNE, 32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) send_request(32'h55, 32'd500000);
    wait_drained();
    // zero capacity, huge refill and rate, short prune
    write_cfg(klim_pkg::CFG_CAPACITY, 32'd0);
    write_cfg(klim_pkg::CFG_REFILL, 32'hFFFF_FFFF);
    write_cfg(klim_pkg::CFG_TPS, 32'd1000000000);
    write_cfg(klim_pkg::CFG_PRUNE, 32'd1);
    send_request(32'h77, 32'd600000);
    send_request(32'h78, 32'd600005);
    wait_drained();
    // max capacity, tiny refill: a new key is allowed
    write_cfg(klim_pkg::CFG_CAPACITY, 32'd65535);
    write_cfg(klim_pkg::CFG_REFILL, 32'd1);
    write_cfg(klim_pkg::CFG_TPS, 32'd1);
    send_request(32'h99, 32'd700000);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 64; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 64; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      write_cfg(klim_pkg::CFG_CAPACITY, (phase == 3) ? 32'd65535 : $urandom_range(1, 6));
      write_cfg(klim_pkg::CFG_REFILL, (phase == 1) ? 32'd0 : $urandom_range(0, 40000));
      write_cfg(klim_pkg::CFG_TPS, (phase == 2) ? 32'd1000000000 : $urandom_range(1, 2000));
      write_cfg(klim_pkg::CFG_PRUNE, (phase == 0) ? 32'd1 : $urandom_range(1000, 300000));
      for (int n = 0; n < 125; n++) random_request();
      wait_drained();
    end

    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
